/* sv/ptq_pkg.sv */
// ----------------------------------------------------------------------------
// ptq_pkg: shared types and constants of the periodic timer event queue
// Field structs, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 48;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  localparam logic [2:0] ST_FIRED   = 3'd0;
  localparam logic [2:0] ST_NONE    = 3'd1;
  localparam logic [2:0] ST_INSERT  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_STOPPED = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] task_handle;
    logic [47:0] deadline;
    logic        repeat_req;
    logic [31:0] period;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] fired_handle;
    logic [47:0] fired_deadline;
    logic [4:0]  pending_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_REMOVE, S_INSERT, S_STOP, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic remove;     // shift out head
    logic insert;     // place pending entry (parallel shift)
    logic rearm;      // insert uses re-armed head instead of input item
    logic clear_rep;  // clear repeat marks of matching handle
    logic emit;       // drive result strobe
    logic [2:0] status;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       due;
    logic       head_rep;
  } sts_t;

endpackage

/* sv/ptq_datapath.sv */
// ----------------------------------------------------------------------------
// ptq_datapath: sorted entry table with shift insert and head removal
// Entries are kept in deadline order; insert places after equal deadlines.
// ----------------------------------------------------------------------------
module ptq_datapath import ptq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  item,
  input  ctl_t      ctl,
  output sts_t      sts,
  output logic      done,
  output out_item_t result
);

  logic [TIME_BITS-1:0] ent_dl  [QUEUE_DEPTH];
  logic [31:0]          ent_per [QUEUE_DEPTH];
  logic [15:0]          ent_hdl [QUEUE_DEPTH];
  logic                 ent_rep [QUEUE_DEPTH];
  logic [CNT_BITS-1:0]  count;
  in_item_t             cur;
  logic [TIME_BITS-1:0] head_dl;
  logic [31:0]          head_per;
  logic [15:0]          head_hdl;
  logic                 head_rep;

  logic [TIME_BITS-1:0] ins_dl;
  logic [31:0]          ins_per;
  logic [15:0]          ins_hdl;
  logic                 ins_rep;
  logic [TIME_BITS:0]   sum;
  logic [QUEUE_DEPTH-1:0] after;  // entry i has deadline > new one and i < count

  assign sum = {1'b0, head_dl} + {{(TIME_BITS-31){1'b0}}, head_per};

  always_comb begin
    if (ctl.rearm) begin
      ins_dl  = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
      ins_per = head_per;
      ins_hdl = head_hdl;
      ins_rep = head_rep;
    end else begin
      ins_dl  = cur.deadline[TIME_BITS-1:0];
      ins_per = cur.period;
      ins_hdl = cur.task_handle;
      ins_rep = cur.repeat_req;
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      after[i] = (CNT_BITS'(i) < count) && (ent_dl[i] > ins_dl);
    end
  end

  assign sts.op       = cur.operation;
  assign sts.full     = (count == CNT_BITS'(QUEUE_DEPTH));
  assign sts.empty    = (count == '0);
  assign sts.due      = cur.deadline[TIME_BITS-1:0] >= ent_dl[0];
  assign sts.head_rep = ent_rep[0];

  always_ff @(posedge clk) begin
    if (ctl.load) cur <= item;
    if (ctl.remove) begin
      head_dl  <= ent_dl[0];
      head_per <= ent_per[0];
      head_hdl <= ent_hdl[0];
      head_rep <= ent_rep[0];
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        ent_dl[i]  <= ent_dl[i+1];
        ent_per[i] <= ent_per[i+1];
        ent_hdl[i] <= ent_hdl[i+1];
        ent_rep[i] <= ent_rep[i+1];
      end
    end
    if (ctl.insert) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (after[i]) begin
          if (i < QUEUE_DEPTH - 1) begin
            ent_dl[(i+1)%QUEUE_DEPTH]  <= ent_dl[i];
            ent_per[(i+1)%QUEUE_DEPTH] <= ent_per[i];
            ent_hdl[(i+1)%QUEUE_DEPTH] <= ent_hdl[i];
            ent_rep[(i+1)%QUEUE_DEPTH] <= ent_rep[i];
          end
        end
        if ((i == 0 || !after[(i+QUEUE_DEPTH-1)%QUEUE_DEPTH]) &&
            (after[i] || CNT_BITS'(i) == count)) begin
          ent_dl[i]  <= ins_dl;
          ent_per[i] <= ins_per;
          ent_hdl[i] <= ins_hdl;
          ent_rep[i] <= ins_rep;
        end
      end
    end
    if (ctl.clear_rep) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (ent_hdl[i] == cur.task_handle) ent_rep[i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.remove && !ctl.insert) begin
      count <= count - CNT_BITS'(1);
    end else if (ctl.insert && !ctl.remove) begin
      count <= count + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      result.status         <= ctl.status;
      result.fired_handle   <= (ctl.status == ST_FIRED) ? head_hdl : '0;
      result.fired_deadline <= (ctl.status == ST_FIRED) ? 48'(head_dl) : '0;
      result.pending_count  <= 5'(count);
    end
  end

endmodule

/* sv/ptq_ctrl.sv */
// ----------------------------------------------------------------------------
// ptq_ctrl: sequencing state machine of the timer event queue
// Decodes the captured item and steps the datapath through it.
// ----------------------------------------------------------------------------
module ptq_ctrl import ptq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic running,
  input  sts_t sts,
  output logic busy,
  output ctl_t ctl
);

  state_t state, state_next;
  logic [2:0] stat, stat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stat  <= ST_NONE;
    end else begin
      state <= state_next;
      stat  <= stat_next;
    end
  end

  always_comb begin
    state_next = state;
    stat_next  = stat;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (sts.op)
          OP_INSERT: begin
            if (!running) begin
              stat_next = ST_STOPPED; state_next = S_DONE;
            end else if (sts.full) begin
              stat_next = ST_FULL; state_next = S_DONE;
            end else begin
              stat_next = ST_INSERT; state_next = S_INSERT;
            end
          end
          OP_TICK: begin
            if (!sts.empty && sts.due) begin
              stat_next = ST_FIRED; state_next = S_REMOVE;
            end else begin
              stat_next = ST_NONE; state_next = S_DONE;
            end
          end
          OP_STOP: begin
            stat_next = ST_CLEARED; state_next = S_STOP;
          end
          default: begin
            stat_next = ST_NONE; state_next = S_DONE;
          end
        endcase
      end
      S_REMOVE: state_next = (sts.head_rep && running) ? S_INSERT : S_DONE;
      S_INSERT: state_next = S_DONE;
      S_STOP:   state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.status    = stat;
    busy          = (state != S_IDLE);
    case (state)
      S_IDLE:   ctl.load = start;
      S_REMOVE: ctl.remove = 1'b1;
      S_INSERT: begin
        ctl.insert = 1'b1;
        ctl.rearm  = (stat == ST_FIRED);
      end
      S_STOP:   ctl.clear_rep = 1'b1;
      S_DONE:   ctl.emit = 1'b1;
      default:  ctl = '0;
    endcase
  end

endmodule

/* sv/periodic_timer_event_queue_unit.sv */
// ----------------------------------------------------------------------------
// periodic_timer_event_queue_unit: earliest-deadline timer event queue
// Sorted 16-entry table with insert, tick and stop-repeat operations.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low; exactly one result
// follows, on a one-cycle done strobe that the receiver cannot stall. An
// item steps through the controller's steps as it needs them: decode,
// head removal, parallel shift insert, result register. A tick with
// nothing due, a rejected insert or an unknown operation goes from decode
// to the result; an insert adds the insert step, a stop-repeat a repeat
// clear step, a tick that fires without re-arming the removal, and a tick
// that re-arms its entry both. busy stays high through the done cycle, so
// the next item is taken in the cycle after done at the earliest. cfg_ready is always high.
module periodic_timer_event_queue_unit import ptq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item,
  output logic      done,
  output out_item_t result,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic running;
  ctl_t ctl;
  sts_t sts;
  logic busy_int;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      running <= cfg_data;
    end
  end

  ptq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start && !busy), .running(running),
    .sts(sts), .busy(busy_int), .ctl(ctl)
  );

  ptq_datapath u_dp (
    .clk(clk), .rst(rst), .item(item), .ctl(ctl),
    .sts(sts), .done(done), .result(result)
  );

  assign busy = busy_int || done;

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(ctl.insert && ctl.clear_rep)) else $error("insert overlaps clear");
  a_done_emit: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> done) else $error("result strobe missing");
  a_count_ok: assert property (@(posedge clk) disable iff (rst)
    done |-> result.pending_count <= 5'(QUEUE_DEPTH)) else $error("count overflow");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised");

endmodule

/* test/periodic_timer_event_queue_unit_test.sv */
// ----------------------------------------------------------------------------
// periodic_timer_event_queue_unit_test: regression of the timer event queue
// Directed and random insert, tick and stop-repeat transactions are sent.
// Each result is checked against a sorted-table predictor kept in the bench.
// ----------------------------------------------------------------------------
module periodic_timer_event_queue_unit_test;
  import ptq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [47:0] TIME_TOP = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_item_t item = '0;
  logic done;
  out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  periodic_timer_event_queue_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [47:0] tbl_deadline [QUEUE_DEPTH];
  logic [31:0] tbl_period [QUEUE_DEPTH];
  logic [15:0] tbl_handle [QUEUE_DEPTH];
  logic        tbl_repeat [QUEUE_DEPTH];
  int          tbl_count = 0;
  logic        run_mode = 1'b0;

  out_item_t expected_results [$];
  int mismatches = 0;
  int idle_cycles = 0;
  logic [47:0] now = '0;
  logic [15:0] hot_handle [4];

  function automatic void table_place(logic [47:0] d, logic [15:0] h, logic r,
                                      logic [31:0] p);
    int pos;
    pos = tbl_count;
    while (pos > 0 && tbl_deadline[pos-1] > d) begin
      tbl_deadline[pos] = tbl_deadline[pos-1];
      tbl_period[pos] = tbl_period[pos-1];
      tbl_handle[pos] = tbl_handle[pos-1];
      tbl_repeat[pos] = tbl_repeat[pos-1];
      pos--;
    end
    tbl_deadline[pos] = d;
    tbl_period[pos] = p;
    tbl_handle[pos] = h;
    tbl_repeat[pos] = r;
    tbl_count++;
  endfunction

  function automatic out_item_t queue_step(in_item_t it);
    out_item_t r;
    logic [47:0] d;
    logic [31:0] p;
    logic [15:0] h;
    logic rp;
    logic [48:0] sum;
    r = '0;
    r.status = ST_NONE;
    if (it.operation == OP_INSERT) begin
      if (!run_mode) r.status = ST_STOPPED;
      else if (tbl_count >= QUEUE_DEPTH) r.status = ST_FULL;
      else begin
        table_place(it.deadline, it.task_handle, it.repeat_req, it.period);
        r.status = ST_INSERT;
      end
    end else if (it.operation == OP_TICK) begin
      if (tbl_count > 0 && it.deadline >= tbl_deadline[0]) begin
        d = tbl_deadline[0];
        p = tbl_period[0];
        h = tbl_handle[0];
        rp = tbl_repeat[0];
        for (int i = 1; i < tbl_count; i++) begin
          tbl_deadline[i-1] = tbl_deadline[i];
          tbl_period[i-1] = tbl_period[i];
          tbl_handle[i-1] = tbl_handle[i];
          tbl_repeat[i-1] = tbl_repeat[i];
        end
        tbl_count--;
        r.status = ST_FIRED;
        r.fired_handle = h;
        r.fired_deadline = d;
        if (rp && run_mode) begin
          sum = {1'b0, d} + {17'd0, p};
          table_place(sum[48] ? TIME_TOP : sum[47:0], h, rp, p);
        end
      end
    end else if (it.operation == OP_STOP) begin
      for (int i = 0; i < tbl_count; i++)
        if (tbl_handle[i] == it.task_handle) tbl_repeat[i] = 1'b0;
      r.status = ST_CLEARED;
    end
    r.pending_count = 5'(tbl_count);
    return r;
  endfunction

  always @(posedge clk) begin
    if (done && !rst) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (result.status !== e.status || result.fired_handle !== e.fired_handle ||
            result.fired_deadline !== e.fired_deadline ||
            result.pending_count !== e.pending_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", e, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("periodic_timer_event_queue_unit regression: fail");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(queue_step(it));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_running(logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    run_mode = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_item(logic [1:0] op, logic [15:0] h,
                                         logic [47:0] d, logic r, logic [31:0] p);
    in_item_t it;
    it.operation = op;
    it.task_handle = h;
    it.deadline = d;
    it.repeat_req = r;
    it.period = p;
    return it;
  endfunction

  task automatic test_stopped();
    send_item(make_item(OP_INSERT, 16'hFFFF, TIME_TOP, 1'b1, 32'hFFFF_FFFF));
    send_item(make_item(OP_TICK, 16'h0, '0, 1'b0, '0));
    send_item(make_item(OP_STOP, 16'h0, '0, 1'b0, '0));
    send_item(make_item(2'd3, 16'hFFFF, TIME_TOP, 1'b1, 32'hFFFF_FFFF));
  endtask

  task automatic test_directed();
    write_running(1'b1);
    send_item(make_item(OP_INSERT, 16'h0000, 48'd0, 1'b0, 32'd0));
    send_item(make_item(OP_INSERT, 16'hFFFF, TIME_TOP, 1'b1, 32'hFFFF_FFFF));
    send_item(make_item(OP_INSERT, 16'h1234, 48'd100, 1'b1, 32'd50));
    send_item(make_item(OP_INSERT, 16'h4321, 48'd100, 1'b0, 32'd7));
    send_item(make_item(OP_TICK, 16'h0, 48'd50, 1'b0, '0));
    send_item(make_item(OP_TICK, 16'h0, 48'd50, 1'b0, '0));
    send_item(make_item(OP_TICK, 16'h0, 48'd100, 1'b0, '0));
    send_item(make_item(OP_TICK, 16'h0, 48'd100, 1'b0, '0));
    send_item(make_item(OP_STOP, 16'h1234, '0, 1'b0, '0));
    send_item(make_item(OP_STOP, 16'hAAAA, '0, 1'b0, '0));
    send_item(make_item(OP_TICK, 16'h0, TIME_TOP, 1'b0, '0));
    send_item(make_item(OP_TICK, 16'h0, TIME_TOP, 1'b0, '0));
    send_item(make_item(OP_TICK, 16'h0, TIME_TOP, 1'b0, '0));
    for (int i = 0; i < 17; i++)
      send_item(make_item(OP_INSERT, 16'(i), 48'd5, 1'b1, 32'd3));
    write_running(1'b0);
    send_item(make_item(OP_INSERT, 16'h1, 48'd1, 1'b0, '0));
    send_item(make_item(OP_TICK, 16'h0, 48'd5, 1'b0, '0));
    send_item(make_item(2'd3, 16'h0, '0, 1'b0, '0));
    write_running(1'b1);
    for (int i = 0; i < 16; i++)
      send_item(make_item(OP_TICK, 16'h0, TIME_TOP, 1'b0, '0));
  endtask

  task automatic test_random(int n);
    in_item_t it;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      it.task_handle = ($urandom_range(0, 1) != 0) ? hot_handle[$urandom_range(0, 3)]
                                                   : 16'($urandom);
      it.repeat_req = 1'($urandom_range(0, 1));
      it.period = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 40));
      if ($urandom_range(0, 15) == 0) it.deadline = 48'({$urandom, $urandom});
      else it.deadline = now + 48'($urandom_range(0, 60));
      if (pick < 40) it.operation = OP_INSERT;
      else if (pick < 85) begin
        it.operation = OP_TICK;
        now = now + 48'($urandom_range(0, 25));
        it.deadline = ($urandom_range(0, 31) == 0) ? TIME_TOP : now;
      end else if (pick < 97) it.operation = OP_STOP;
      else it.operation = 2'd3;
      send_item(it);
    end
  endtask

  task automatic test_drain_high();
    for (int i = 0; i < 24; i++)
      send_item(make_item(OP_TICK, 16'h0, TIME_TOP, 1'b0, '0));
  endtask

  initial begin
    for (int i = 0; i < 4; i++) hot_handle[i] = 16'($urandom);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_stopped();
    test_directed();
    test_random(150);
    write_running(1'b0);
    test_random(50);
    write_running(1'b1);
    now = 48'hFFFF_FFFF_0000;
    test_random(200);
    test_drain_high();
    drain();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("periodic_timer_event_queue_unit regression: pass");
    else
      $display("periodic_timer_event_queue_unit regression: fail");
    $finish;
  end
endmodule
